// ----- rtl/u8s_pkg.sv -----
// Shared types and constants for the UTF-8 text sanitizer.
`timescale 1ns / 1ps
`default_nettype none

package u8s_pkg;

    localparam logic [7:0] QMARK_CHAR   = 8'h3F;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam int         JOB_LANES    = 4;
    localparam int         QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_out;
        logic       any_changed;
    } out_t;

    // One burst of output bytes caused by one input byte.
    typedef struct packed {
        logic [JOB_LANES-1:0][7:0] data;
        logic [2:0]                count;
        logic                      last;
        logic                      changed;
    } job_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

`default_nettype wire

// ----- rtl/u8s_front.sv -----
// Front end: UTF-8 sequence tracking and output burst formation.
`timescale 1ns / 1ps
`default_nettype none

module u8s_front
    import u8s_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_accept,
    input  wire in_t  in_data,
    output logic      push_valid,
    output job_t      push_job
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] hcnt_reg, hcnt_next;
    logic [1:0] need_reg, need_next;
    logic       chg_reg, chg_next;

    logic [7:0] b;
    logic       fr_emit, fr_hold, fr_chg;
    logic [1:0] fr_need;
    logic [7:0] fr_byte;
    logic [7:0] lo, hi;
    logic       cont_ok;

    logic [2:0] pre_cnt;
    logic       pre_held;
    logic       tail;
    logic [7:0] tail_byte;
    logic       chg_total;

    assign b = in_data.byte_in;

    // Classification of a byte met as the start of a new sequence.
    always_comb begin
        fr_emit = 1'b0;
        fr_hold = 1'b0;
        fr_chg  = 1'b0;
        fr_need = 2'd0;
        fr_byte = b;
        if (b == 8'h00) begin
            fr_emit = 1'b1;
            fr_byte = QMARK_CHAR;
            fr_chg  = 1'b1;
        end else if (b < 8'h80) begin
            fr_emit = 1'b1;
            if (b < CTRL_LIMIT) begin
                fr_byte = SPACE_CHAR;
                fr_chg  = 1'b1;
            end
        end else if (b inside {[8'hC2:8'hDF]}) begin
            fr_hold = 1'b1;
            fr_need = 2'd1;
        end else if (b inside {[8'hE0:8'hEF]}) begin
            fr_hold = 1'b1;
            fr_need = 2'd2;
        end else if (b inside {[8'hF0:8'hF4]}) begin
            fr_hold = 1'b1;
            fr_need = 2'd3;
        end else begin
            fr_emit = 1'b1;
            fr_byte = QMARK_CHAR;
            fr_chg  = 1'b1;
        end
    end

    // The second byte of some sequences has a narrower legal range.
    always_comb begin
        lo = 8'h80;
        hi = 8'hBF;
        if (hcnt_reg == 2'd1) begin
            case (held_reg[0])
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
            endcase
        end
        cont_ok = (b >= lo) && (b <= hi);
    end

    always_comb begin
        held_next = held_reg;
        hcnt_next = hcnt_reg;
        need_next = need_reg;
        chg_next  = chg_reg;
        pre_cnt   = 3'd0;
        pre_held  = 1'b0;
        tail      = 1'b0;
        tail_byte = fr_byte;
        chg_total = chg_reg;

        if (hcnt_reg == 2'd0 || need_reg == 2'd0) begin
            tail      = fr_emit;
            chg_total = chg_reg | fr_chg;
            if (fr_hold) begin
                held_next[0] = b;
                hcnt_next    = 2'd1;
                need_next    = fr_need;
            end else begin
                hcnt_next = 2'd0;
                need_next = 2'd0;
            end
        end else if (cont_ok) begin
            if (need_reg == 2'd1) begin
                pre_cnt   = {1'b0, hcnt_reg};
                pre_held  = 1'b1;
                tail      = 1'b1;
                tail_byte = b;
                hcnt_next = 2'd0;
                need_next = 2'd0;
            end else if (hcnt_reg < 2'd3) begin
                held_next[hcnt_reg] = b;
                hcnt_next = hcnt_reg + 2'd1;
                need_next = need_reg - 2'd1;
            end
        end else begin
            // Failed sequence: every held byte becomes '?', then restart on b.
            pre_cnt   = {1'b0, hcnt_reg};
            tail      = fr_emit;
            chg_total = 1'b1;
            if (fr_hold) begin
                held_next[0] = b;
                hcnt_next    = 2'd1;
                need_next    = fr_need;
            end else begin
                hcnt_next = 2'd0;
                need_next = 2'd0;
            end
        end

        if (in_data.last_byte) begin
            // Whatever is still held at the end of the string becomes '?'.
            if (hcnt_next != 2'd0) begin
                pre_cnt   = pre_cnt + {1'b0, hcnt_next};
                chg_total = 1'b1;
            end
            held_next[0] = 8'h00;
            held_next[1] = 8'h00;
            held_next[2] = 8'h00;
            hcnt_next    = 2'd0;
            need_next    = 2'd0;
            chg_next     = 1'b0;
        end else begin
            chg_next = chg_total;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (3'(i) < pre_cnt) begin
                push_job.data[i] = pre_held ? held_reg[i] : QMARK_CHAR;
            end else begin
                push_job.data[i] = tail_byte;
            end
        end
        push_job.data[3] = (pre_cnt == 3'd4) ? QMARK_CHAR : tail_byte;
        push_job.count   = pre_cnt + {2'b00, tail};
        push_job.last    = in_data.last_byte;
        push_job.changed = chg_total;
        push_valid       = in_accept && (push_job.count != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg[0] <= 8'h00;
            held_reg[1] <= 8'h00;
            held_reg[2] <= 8'h00;
            hcnt_reg    <= 2'd0;
            need_reg    <= 2'd0;
            chg_reg     <= 1'b0;
        end else if (in_accept) begin
            held_reg <= held_next;
            hcnt_reg <= hcnt_next;
            need_reg <= need_next;
            chg_reg  <= chg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u8s_queue.sv -----
// Short burst queue between the front end and the output serializer.
`timescale 1ns / 1ps
`default_nettype none

module u8s_queue
    import u8s_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    input  wire job_t push_job,
    output logic      full,
    output hs_t       pop_hs,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          do_pop;

    assign full         = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_hs.valid = (cnt_reg != '0);
    assign pop_hs.ready = pop_ready;
    assign pop_job      = mem_reg[rd_ptr_reg];
    assign do_pop       = pop_hs.valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(push_valid) - (PW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u8s_back.sv -----
// Back end: serializes each queued burst into single output bytes.
`timescale 1ns / 1ps
`default_nettype none

module u8s_back
    import u8s_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire hs_t  pop_hs,
    input  wire job_t pop_job,
    output logic      pop_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    job_t       job_reg;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       final_lane;
    logic       load;

    assign final_lane = ({1'b0, idx_reg} == (job_reg.count - 3'd1));
    assign pop_ready  = !valid_reg || (m_ready && final_lane);
    assign load       = pop_hs.valid && pop_hs.ready;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = 2'd0;
            valid_next = 1'b1;
        end else if (valid_reg && m_ready) begin
            if (final_lane) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= pop_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid            = valid_reg;
    assign m_data.byte_out    = job_reg.data[idx_reg];
    assign m_data.last_out    = job_reg.last && final_lane;
    assign m_data.any_changed = job_reg.last && final_lane && job_reg.changed;

endmodule

`default_nettype wire

// ----- rtl/utf8_text_sanitizer_top.sv -----
// Top level of the UTF-8 text sanitizer.
//
// The block takes a string one byte per transaction on the s_ channel and
// returns a cleaned copy, one byte per transaction, on the m_ channel. Each
// input byte yields exactly one output byte: valid UTF-8 passes unchanged,
// bytes of a broken or unfinished sequence become '?', a NUL byte becomes
// '?' too, and other control bytes below 0x20 become a space. The output
// transaction flagged last_out closes the string and carries any_changed.
//
// The front end keeps the sequence state and turns each input byte into a
// burst of zero to four output bytes; a four-entry queue holds the bursts
// and the back end drains them one byte per cycle unless m_ready stalls it.
// A lone byte passes through a queue entry and the back end's job register; a
// multibyte sequence is held until its final byte arrives and leaves as a burst.
// Throughput is one byte per cycle without stalls, set by the single output lane.
//
// A synchronous active-low reset empties the queue and clears the sequence
// state. When the receiver stalls, the current byte holds on m_data, the
// queue fills, and s_ready drops only once all four queue entries are used.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_sanitizer_top
    import u8s_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic push_valid;
    job_t push_job;
    logic q_full;
    hs_t  pop_hs;
    logic pop_ready;
    job_t pop_job;
    logic in_accept;

    // The queue only refuses a burst when every entry is taken.
    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    u8s_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_data    (s_data),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    u8s_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop_hs     (pop_hs),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    u8s_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_hs    (pop_hs),
        .pop_job   (pop_job),
        .pop_ready (pop_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/u8s_checker.sv -----
// Port-level checker for the UTF-8 text sanitizer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module u8s_checker
    import u8s_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // A stalled input transaction keeps its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction changed while stalled");

    // A stalled output transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output transaction changed while stalled");

    // The change flag is only reported on the closing byte of a string.
    a_changed_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.any_changed |-> m_data.last_out)
        else $error("any_changed set on a byte that is not last");

    // Control bytes never leave the block.
    a_no_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_out >= CTRL_LIMIT))
        else $error("control byte on the output");

    // Reset leaves no output transaction pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind utf8_text_sanitizer_top u8s_checker u_u8s_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
